// ===== design/hill_pkg.sv =====
package hill_pkg;

    localparam int MAX_BLOCK   = 4;
    localparam int SYMBOL_BITS = 6;
    localparam int KEY_ROWS    = 4;
    localparam int KEY_W       = 24;

    localparam int N_MAX      = (MAX_BLOCK < KEY_ROWS) ? MAX_BLOCK : KEY_ROWS;
    localparam int BSIZE_W    = 3;
    localparam int MOD_W      = 7;
    localparam int MOD_MAX    = 1 << SYMBOL_BITS;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = KEY_W;

    localparam int ROW_W      = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int KROW_IDX_W = (KEY_ROWS > 1) ? $clog2(KEY_ROWS) : 1;
    localparam int CNT_W      = $clog2(N_MAX + 1);
    localparam int KROW_W     = (MAX_BLOCK * SYMBOL_BITS > KEY_W) ?
                                MAX_BLOCK * SYMBOL_BITS : KEY_W;
    localparam int PROD_W     = 2 * SYMBOL_BITS;
    localparam int ACC_W      = PROD_W + $clog2(MAX_BLOCK);
    localparam int RED_STEPS  = 4;
    localparam int RED_CYCLES = (ACC_W + RED_STEPS - 1) / RED_STEPS;
    localparam int RED_CNT_W  = (RED_CYCLES > 1) ? $clog2(RED_CYCLES) : 1;
    localparam int TRIAL_W    = MOD_W + RED_CYCLES * RED_STEPS;

    localparam logic [BSIZE_W-1:0]     BLOCK_SIZE_RST = BSIZE_W'(2);
    localparam logic [MOD_W-1:0]       MODULUS_RST    = MOD_W'(26);
    localparam logic [SYMBOL_BITS-1:0] PAD_SYMBOL_RST = SYMBOL_BITS'(23);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_SIZE = 3'd0,
        REG_MODULUS    = 3'd1,
        REG_PAD_SYMBOL = 3'd2,
        REG_KEY_ROW_A  = 3'd3,
        REG_KEY_ROW_B  = 3'd4,
        REG_KEY_ROW_C  = 3'd5,
        REG_KEY_ROW_D  = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_RED,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic first_row;
        logic start_row;
        logic mac;
        logic red;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic block_go;
        logic mac_last;
        logic red_last;
        logic row_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/hill_sym_if.sv =====
interface hill_sym_if;
    import hill_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SYMBOL_BITS-1:0] symbol_index;
    logic                   final_flag;

    modport source (output valid, output symbol_index, output final_flag, input ready);
    modport sink (input valid, input symbol_index, input final_flag, output ready);
endinterface

// ===== design/hill_res_if.sv =====
interface hill_res_if;
    import hill_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SYMBOL_BITS-1:0] cipher_index;
    logic                   block_end;

    modport source (output valid, output cipher_index, output block_end, input ready);
    modport sink (input valid, input cipher_index, input block_end, output ready);
endinterface

// ===== design/hill_cfg_if.sv =====
interface hill_cfg_if;
    import hill_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/hill_block_cipher_mod_m.sv =====
// Hill cipher engine over an alphabet of configurable size. Symbols arrive one beat at a
// time and are buffered until a block of block_size symbols is held, or until a beat with
// final_flag set, which pads the rest of the block with pad_symbol. Each block then yields
// block_size result beats, the last one marked by block_end. Input beats are taken one per
// cycle while a block fills; once a block is complete the input is held off until its last
// result has been written to the output register. Each result is built in the single shared
// multiply-accumulate unit, then in the iterative modulo reducer, and is then loaded into
// the output register once that register is free. Configuration beats are always accepted
// and must only be issued while no block is in progress.
module hill_block_cipher_mod_m (
    input logic        clk,
    input logic        rst_n,
    hill_sym_if.sink   sym,
    hill_res_if.source res,
    hill_cfg_if.sink   cfg
);
    import hill_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    hill_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sym.valid),
        .status   (status),
        .cmd      (cmd)
    );

    hill_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sym_valid    (sym.valid),
        .symbol_index (sym.symbol_index),
        .final_flag   (sym.final_flag),
        .cfg_valid    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .out_valid    (res.valid),
        .out_ready    (res.ready),
        .cipher_index (res.cipher_index),
        .block_end    (res.block_end)
    );

    assign sym.ready = cmd.in_ready;
    assign cfg.ready = 1'b1;
endmodule

// ===== design/hill_ctrl.sv =====
module hill_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  hill_pkg::dp_status_t status,
    output hill_pkg::dp_cmd_t    cmd
);
    import hill_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid && status.block_go)
                begin
                    cmd.first_row = 1'b1;
                    cmd.start_row = 1'b1;
                    state_next    = ST_MAC;
                end
            end
            ST_MAC:
            begin
                cmd.mac = 1'b1;
                if (status.mac_last)
                begin
                    state_next = ST_RED;
                end
            end
            ST_RED:
            begin
                cmd.red = 1'b1;
                if (status.red_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (status.row_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.start_row = 1'b1;
                        state_next    = ST_MAC;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// ===== design/hill_dp.sv =====
module hill_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  hill_pkg::dp_cmd_t                cmd,
    output hill_pkg::dp_status_t             status,
    input  logic                             sym_valid,
    input  logic [hill_pkg::SYMBOL_BITS-1:0] symbol_index,
    input  logic                             final_flag,
    input  logic                             cfg_valid,
    input  logic [hill_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hill_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [hill_pkg::SYMBOL_BITS-1:0] cipher_index,
    output logic                             block_end
);
    import hill_pkg::*;

    logic [BSIZE_W-1:0]     block_size_reg;
    logic [MOD_W-1:0]       modulus_reg;
    logic [SYMBOL_BITS-1:0] pad_reg;
    logic [KEY_W-1:0]       key_reg [KEY_ROWS];

    logic [SYMBOL_BITS-1:0] buf_reg [MAX_BLOCK];
    logic [CNT_W-1:0]       fill_reg;
    logic [CNT_W-1:0]       fill_next;

    logic [ROW_W-1:0]       row_reg;
    logic [ROW_W-1:0]       col_reg;
    logic [RED_CNT_W-1:0]   red_cnt_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [ACC_W-1:0]       acc_next;

    logic                   out_valid_reg;
    logic [SYMBOL_BITS-1:0] cipher_reg;
    logic                   end_reg;

    logic [CNT_W-1:0]       n_eff;
    logic [MOD_W-1:0]       mod_eff;
    logic [CNT_W-1:0]       fill_eff;
    logic [CNT_W-1:0]       fill_inc;
    logic                   accept;
    logic [KROW_W-1:0]      key_vec;
    logic [SYMBOL_BITS-1:0] key_sel;
    logic [SYMBOL_BITS-1:0] sym_sel;
    logic [PROD_W-1:0]      prod;
    logic [TRIAL_W-1:0]     rem;
    logic [TRIAL_W-1:0]     trial;

    always_comb
    begin
        if (block_size_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (block_size_reg > BSIZE_W'(N_MAX))
        begin
            n_eff = CNT_W'(N_MAX);
        end
        else
        begin
            n_eff = CNT_W'(block_size_reg);
        end

        if (modulus_reg < MOD_W'(2))
        begin
            mod_eff = MOD_W'(2);
        end
        else if (modulus_reg > MOD_W'(MOD_MAX))
        begin
            mod_eff = MOD_W'(MOD_MAX);
        end
        else
        begin
            mod_eff = modulus_reg;
        end
    end

    // A count left over from a larger block size drops the held symbols.
    assign accept   = sym_valid && cmd.in_ready;
    assign fill_eff = (fill_reg >= n_eff) ? '0 : fill_reg;
    assign fill_inc = fill_eff + CNT_W'(1);

    always_comb
    begin
        fill_next = fill_reg;
        if (accept)
        begin
            fill_next = status.block_go ? '0 : fill_inc;
        end
    end

    assign status.block_go = final_flag || (fill_inc >= n_eff);
    assign status.mac_last = (CNT_W'(col_reg) == (n_eff - CNT_W'(1)));
    assign status.row_last = (CNT_W'(row_reg) == (n_eff - CNT_W'(1)));
    assign status.red_last = (red_cnt_reg == RED_CNT_W'(RED_CYCLES - 1));
    assign status.out_free = !out_valid_reg || out_ready;

    assign key_vec = KROW_W'(key_reg[KROW_IDX_W'(row_reg)]);
    assign key_sel = key_vec[col_reg * SYMBOL_BITS +: SYMBOL_BITS];
    assign sym_sel = buf_reg[col_reg];
    assign prod    = PROD_W'(key_sel) * PROD_W'(sym_sel);

    // Restoring reduction, several trial subtractions of the shifted modulus per cycle.
    always_comb
    begin
        rem   = TRIAL_W'(acc_reg);
        trial = '0;
        for (int t = 0; t < RED_STEPS; t++)
        begin
            trial = TRIAL_W'(mod_eff) <<
                    (RED_CYCLES * RED_STEPS - 1 - RED_STEPS * int'(red_cnt_reg) - t);
            if (rem >= trial)
            begin
                rem = rem - trial;
            end
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.start_row)
        begin
            acc_next = '0;
        end
        else if (cmd.mac)
        begin
            acc_next = acc_reg + ACC_W'(prod);
        end
        else if (cmd.red)
        begin
            acc_next = ACC_W'(rem);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= BLOCK_SIZE_RST;
            modulus_reg    <= MODULUS_RST;
            pad_reg        <= PAD_SYMBOL_RST;
            for (int r = 0; r < KEY_ROWS; r++)
            begin
                key_reg[r] <= KEY_W'(1) << (r * SYMBOL_BITS);
            end
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BLOCK_SIZE: block_size_reg <= cfg_data[BSIZE_W-1:0];
                REG_MODULUS:    modulus_reg    <= cfg_data[MOD_W-1:0];
                REG_PAD_SYMBOL: pad_reg        <= cfg_data[SYMBOL_BITS-1:0];
                REG_KEY_ROW_A:  key_reg[0]     <= cfg_data[KEY_W-1:0];
                REG_KEY_ROW_B:  key_reg[1]     <= cfg_data[KEY_W-1:0];
                REG_KEY_ROW_C:  key_reg[2]     <= cfg_data[KEY_W-1:0];
                REG_KEY_ROW_D:  key_reg[3]     <= cfg_data[KEY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // A final beat pads every later slot of the block in the same cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int j = 0; j < MAX_BLOCK; j++)
            begin
                if (CNT_W'(j) == fill_eff)
                begin
                    buf_reg[j] <= symbol_index;
                end
                else if (final_flag && (CNT_W'(j) > fill_eff))
                begin
                    buf_reg[j] <= pad_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (cmd.load_out)
        begin
            cipher_reg <= acc_reg[SYMBOL_BITS-1:0];
            end_reg    <= status.row_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            red_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;

            if (cmd.first_row)
            begin
                row_reg <= '0;
            end
            else if (cmd.load_out)
            begin
                row_reg <= row_reg + ROW_W'(1);
            end

            if (cmd.start_row)
            begin
                col_reg     <= '0;
                red_cnt_reg <= '0;
            end
            else if (cmd.mac)
            begin
                col_reg <= col_reg + ROW_W'(1);
            end
            else if (cmd.red)
            begin
                red_cnt_reg <= red_cnt_reg + RED_CNT_W'(1);
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign cipher_index = cipher_reg;
    assign block_end    = end_reg;
endmodule

// ===== design/hill_chk.sv =====
module hill_chk (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             sym_valid,
    input logic                             sym_ready,
    input logic                             sym_final,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [hill_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [hill_pkg::CFG_DATA_W-1:0]  cfg_data,
    input logic                             res_valid,
    input logic                             res_ready,
    input logic [hill_pkg::SYMBOL_BITS-1:0] res_cipher,
    input logic                             res_end
);
    import hill_pkg::*;

    logic [MOD_W-1:0] modulus_reg;
    logic [MOD_W-1:0] mod_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RST;
        end
        else if (cfg_valid && cfg_ready && (cfg_index == REG_MODULUS))
        begin
            modulus_reg <= cfg_data[MOD_W-1:0];
        end
    end

    assign mod_eff = (modulus_reg < MOD_W'(2)) ? MOD_W'(2) :
                     (modulus_reg > MOD_W'(MOD_MAX)) ? MOD_W'(MOD_MAX) : modulus_reg;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_cipher) && $stable(res_end))
        else $error("result beat changed while stalled");

    a_res_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (MOD_W'(res_cipher) < mod_eff))
        else $error("cipher index not below the modulus");

    a_final_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && sym_ready && sym_final |=> !sym_ready)
        else $error("input taken right after a final beat");

    a_mid_block_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_end |-> !sym_ready)
        else $error("input open while a block is still being emitted");
endmodule

bind hill_block_cipher_mod_m hill_chk u_hill_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .sym_valid  (sym.valid),
    .sym_ready  (sym.ready),
    .sym_final  (sym.final_flag),
    .cfg_valid  (cfg.valid),
    .cfg_ready  (cfg.ready),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_cipher (res.cipher_index),
    .res_end    (res.block_end)
);

// ===== tb/sv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hill_pkg::*;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int DRAIN_CYCLES    = 64;
    localparam int HOLD_AT_BEAT    = 150;
    localparam int HOLD_CYCLES     = 300;
    localparam int RAND_PER_PHASE  = 40;

    localparam int KEYS_RANDOM = 0;
    localparam int KEYS_ONES   = 1;
    localparam int KEYS_ZERO   = 2;

    typedef enum int {RX_FREE, RX_COIN, RX_SLOW, RX_TOGGLE} rx_mode_t;

    typedef struct packed {
        logic [SYMBOL_BITS-1:0] symbol;
        logic                   fin;
    } plain_beat_t;

    typedef struct packed {
        logic [SYMBOL_BITS-1:0] cipher;
        logic                   blk_end;
    } cipher_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    hill_sym_if sym_bus ();
    hill_res_if res_bus ();
    hill_cfg_if cfg_bus ();

    hill_block_cipher_mod_m dut (
        .clk   (clk),
        .rst_n (rst_n),
        .sym   (sym_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    always #1 clk = ~clk;

    plain_beat_t  plain_q[$];
    cipher_beat_t cipher_exp_q[$];

    // Shadow of the block's registers and symbol store.
    logic [BSIZE_W-1:0]     sh_bsize = BLOCK_SIZE_RST;
    logic [MOD_W-1:0]       sh_mod   = MODULUS_RST;
    logic [SYMBOL_BITS-1:0] sh_pad   = PAD_SYMBOL_RST;
    logic [KEY_W-1:0]       sh_key [0:KEY_ROWS-1];
    logic [SYMBOL_BITS-1:0] sh_held [0:MAX_BLOCK-1];
    logic [2:0]             sh_fill  = 3'd0;

    int  beats_queued = 0;
    int  beats_in     = 0;
    int  cipher_seen  = 0;
    int  settings     = 0;
    int  mismatches   = 0;
    int  stall_cycles = 0;
    bit  sym_fire     = 1'b0;
    bit  res_fire     = 1'b0;
    bit  cfg_fire     = 1'b0;

    int  burst_left = 1;
    int  gap_left   = 0;

    rx_mode_t rx_mode   = RX_FREE;
    int       mode_left = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;

    initial begin
        for (int r = 0; r < KEY_ROWS; r++)
        begin
            sh_key[r] = KEY_W'(1) << (SYMBOL_BITS * r);
        end
        for (int r = 0; r < MAX_BLOCK; r++)
        begin
            sh_held[r] = '0;
        end
    end

    function automatic void hill_encipher(input logic [SYMBOL_BITS-1:0] sym,
                                          input logic fin);
        int n;
        int m;
        int acc;
        int i;
        int j;
        int k;
        int s;
        cipher_beat_t cb;
        n = sh_bsize;
        if (n < 1) n = 1;
        if (n > N_MAX) n = N_MAX;
        m = sh_mod;
        if (m < 2) m = 2;
        if (m > MOD_MAX) m = MOD_MAX;
        if (sh_fill >= n) sh_fill = 3'd0;
        sh_held[sh_fill] = sym;
        sh_fill = sh_fill + 3'd1;
        if (sh_fill < n && !fin) return;
        for (i = sh_fill; i < n; i++)
        begin
            sh_held[i] = sh_pad;
        end
        for (i = 0; i < n; i++)
        begin
            acc = 0;
            for (j = 0; j < n; j++)
            begin
                k = sh_key[i][j*SYMBOL_BITS +: SYMBOL_BITS] % m;
                s = sh_held[j] % m;
                acc = (acc + k * s) % m;
            end
            cb.cipher = SYMBOL_BITS'(acc);
            cb.blk_end = (i == n - 1);
            cipher_exp_q.push_back(cb);
        end
        sh_fill = 3'd0;
    endfunction

    function automatic void flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("mismatch %0d: %s", mismatches, what);
    endfunction

    always @(posedge clk)
    begin
        cipher_beat_t got;
        cipher_beat_t want;
        sym_fire = sym_bus.valid && sym_bus.ready;
        res_fire = res_bus.valid && res_bus.ready;
        cfg_fire = cfg_bus.valid && cfg_bus.ready;
        if (cfg_fire)
        begin
            case (cfg_bus.index)
                REG_BLOCK_SIZE: sh_bsize = cfg_bus.data[BSIZE_W-1:0];
                REG_MODULUS:    sh_mod = cfg_bus.data[MOD_W-1:0];
                REG_PAD_SYMBOL: sh_pad = cfg_bus.data[SYMBOL_BITS-1:0];
                REG_KEY_ROW_A:  sh_key[0] = cfg_bus.data;
                REG_KEY_ROW_B:  sh_key[1] = cfg_bus.data;
                REG_KEY_ROW_C:  sh_key[2] = cfg_bus.data;
                REG_KEY_ROW_D:  sh_key[3] = cfg_bus.data;
                default: ;
            endcase
        end
        if (sym_fire)
        begin
            beats_in++;
            hill_encipher(sym_bus.symbol_index, sym_bus.final_flag);
        end
        if (res_fire)
        begin
            cipher_seen++;
            got.cipher = res_bus.cipher_index;
            got.blk_end = res_bus.block_end;
            if (cipher_exp_q.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected cipher beat %0d, block_end %0b",
                                        got.cipher, got.blk_end));
            end
            else
            begin
                want = cipher_exp_q.pop_front();
                if (got !== want)
                begin
                    flag_mismatch($sformatf("expected cipher %0d end %0b, got cipher %0d end %0b",
                                            want.cipher, want.blk_end, got.cipher, got.blk_end));
                end
            end
        end
        if (sym_fire || res_fire || cfg_fire) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= WATCHDOG_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Plaintext sender: bursts of beats separated by random gaps.
    always @(negedge clk)
    begin
        plain_beat_t pb;
        if (!sym_bus.valid || sym_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                sym_bus.valid <= 1'b0;
            end
            else if (plain_q.size() > 0)
            begin
                pb = plain_q.pop_front();
                sym_bus.valid <= 1'b1;
                sym_bus.symbol_index <= pb.symbol;
                sym_bus.final_flag <= pb.fin;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                sym_bus.valid <= 1'b0;
            end
        end
    end

    // Cipher receiver: its own stall pattern, plus one long hold-off to back up the input.
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(8, 80);
        end
        else
        begin
            mode_left--;
        end
        if (!hold_done && beats_in >= HOLD_AT_BEAT)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_bus.ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_FREE:  res_bus.ready <= 1'b1;
                RX_COIN:  res_bus.ready <= 1'($urandom_range(0, 1));
                RX_SLOW:  res_bus.ready <= ($urandom_range(0, 3) == 0);
                default:  res_bus.ready <= ~res_bus.ready;
            endcase
        end
    end

    function automatic void queue_plain(input int sym, input bit fin);
        plain_beat_t pb;
        pb.symbol = SYMBOL_BITS'(sym);
        pb.fin = fin;
        plain_q.push_back(pb);
        beats_queued++;
    endfunction

    task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= value;
        do @(posedge clk); while (!cfg_bus.ready);
    endtask

    function automatic logic [KEY_W-1:0] pick_key(input int key_mode);
        if (key_mode == KEYS_ONES) return {KEY_W{1'b1}};
        if (key_mode == KEYS_ZERO) return '0;
        return KEY_W'($urandom);
    endfunction

    task automatic apply_setting(input int bs, input int md, input int pad,
                                 input int key_mode);
        cfg_write(REG_BLOCK_SIZE, CFG_DATA_W'(bs));
        cfg_write(REG_MODULUS, CFG_DATA_W'(md));
        cfg_write(REG_PAD_SYMBOL, CFG_DATA_W'(pad));
        cfg_write(REG_KEY_ROW_A, pick_key(key_mode));
        cfg_write(REG_KEY_ROW_B, pick_key(key_mode));
        cfg_write(REG_KEY_ROW_C, pick_key(key_mode));
        cfg_write(REG_KEY_ROW_D, pick_key(key_mode));
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
        settings++;
    endtask

    // Random messages, then wait for the block to drain. With leave_partial the phase
    // ends holding three symbols so the next setting starts with a stale partial block.
    task automatic play(input int n_rand, input int md, input bit leave_partial);
        int m;
        int k;
        int sym;
        m = (md < 2) ? 2 : (md > MOD_MAX) ? MOD_MAX : md;
        for (k = 0; k < n_rand; k++)
        begin
            sym = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, m - 1);
            queue_plain(sym, (k == n_rand - 1) || ($urandom_range(0, 5) == 0));
        end
        if (leave_partial)
        begin
            for (k = 0; k < 3; k++)
            begin
                queue_plain($urandom_range(0, m - 1), 1'b0);
            end
        end
        do @(negedge clk); while (beats_in != beats_queued || cipher_exp_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial begin
        sym_bus.valid = 1'b0;
        sym_bus.symbol_index = '0;
        sym_bus.final_flag = 1'b0;
        res_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_BLOCK_SIZE;
        cfg_bus.data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Reset settings: identity key, pairs, out-of-alphabet symbols, a padded flush.
        queue_plain(0, 1'b0);
        queue_plain(25, 1'b0);
        queue_plain(63, 1'b0);
        queue_plain(63, 1'b0);
        queue_plain(26, 1'b1);
        queue_plain(1, 1'b0);
        queue_plain(0, 1'b1);
        play(0, 26, 1'b0);

        apply_setting(4, 64, 63, KEYS_ONES);
        queue_plain(63, 1'b0);
        queue_plain(63, 1'b0);
        queue_plain(63, 1'b0);
        queue_plain(63, 1'b0);
        queue_plain(0, 1'b1);
        queue_plain(1, 1'b0);
        queue_plain(2, 1'b0);
        queue_plain(3, 1'b1);
        queue_plain(62, 1'b1);
        play(RAND_PER_PHASE, 64, 1'b1);

        apply_setting(2, 26, $urandom_range(0, 63), KEYS_RANDOM);
        play(RAND_PER_PHASE, 26, 1'b0);
        apply_setting(1, 2, 0, KEYS_ZERO);
        play(RAND_PER_PHASE, 2, 1'b0);
        apply_setting(0, 0, $urandom_range(0, 63), KEYS_RANDOM);
        play(RAND_PER_PHASE, 0, 1'b0);
        apply_setting(7, 127, $urandom_range(0, 63), KEYS_RANDOM);
        play(RAND_PER_PHASE, 127, 1'b0);
        apply_setting(3, 1, $urandom_range(0, 63), KEYS_ONES);
        play(RAND_PER_PHASE, 1, 1'b0);
        apply_setting(5, 65, $urandom_range(0, 63), KEYS_RANDOM);
        play(RAND_PER_PHASE, 65, 1'b0);
        apply_setting(4, 37, $urandom_range(0, 63), KEYS_RANDOM);
        play(RAND_PER_PHASE, 37, 1'b0);
        begin
            int bs;
            int md;
            bs = $urandom_range(0, 7);
            md = $urandom_range(0, 127);
            apply_setting(bs, md, $urandom_range(0, 63), KEYS_RANDOM);
            play(RAND_PER_PHASE, md, 1'b0);
        end

        if (cipher_exp_q.size() != 0)
        begin
            flag_mismatch($sformatf("%0d expected cipher beats never arrived",
                                    cipher_exp_q.size()));
        end
        $display("Sent %0d plaintext beats under %0d register settings plus reset values,",
                 beats_in, settings);
        $display("checked %0d cipher beats, including one long output hold-off.", cipher_seen);
        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/hill_pkg.sv
design/hill_sym_if.sv
design/hill_res_if.sv
design/hill_cfg_if.sv
design/hill_ctrl.sv
design/hill_dp.sv
design/hill_block_cipher_mod_m.sv
design/hill_chk.sv
tb/sv/tb_top.sv
